>>> hw/rtl/iiel_pkg.sv
// ----------------------------------------------------------------------------
// iiel_pkg
// Shared types and codes for the indexed insert/erase list unit: command and
// status codes, the shift operation broadcast to the cell row, and the
// request and response beat layouts.
// ----------------------------------------------------------------------------
package iiel_pkg;

   // Command codes on the request beat
   localparam logic [2:0] CMD_PUSH   = 3'd0;
   localparam logic [2:0] CMD_POP    = 3'd1;
   localparam logic [2:0] CMD_INSERT = 3'd2;
   localparam logic [2:0] CMD_ERASE  = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;
   localparam logic [2:0] CMD_CLEAR  = 3'd5;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // Operation broadcast to every cell in the row
   typedef enum logic [1:0] {
      OP_HOLD  = 2'd0,
      OP_OPEN  = 2'd1,   // write at a position, shift the tail up
      OP_CLOSE = 2'd2    // drop a position, shift the tail down
   } shift_op_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
      logic [6:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [6:0]         count;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
   } rsp_type;

endpackage

>>> hw/rtl/iiel_cell.sv
// ----------------------------------------------------------------------------
// iiel_cell
// One storage cell of the list row. Holds one entry, takes its left or right
// neighbor's entry on a shift, loads the new word at its own position, and
// drives read and back taps when its index is selected.
// ----------------------------------------------------------------------------
module iiel_cell #(
   parameter int INDEX = 0,
   parameter int XW    = 8
) (
   input  logic                       clock,
   input  iiel_pkg::shift_op_type     op,
   input  logic [XW-1:0]              pos,
   input  logic [XW-1:0]              count,
   input  logic signed [31:0]         value,
   input  logic signed [31:0]         left_value,
   input  logic signed [31:0]         right_value,
   input  logic [XW-1:0]              rd_idx,
   input  logic [XW-1:0]              back_idx,
   output logic signed [31:0]         entry_value,
   output logic signed [31:0]         rd_tap,
   output logic signed [31:0]         back_tap
);
   import iiel_pkg::*;

   localparam logic [XW-1:0] IDX = XW'(INDEX);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (op)
         OP_OPEN: begin
            if (IDX == pos) begin
               entry_in = value;
            end else if ((IDX > pos) && (IDX <= count)) begin
               entry_in = left_value;
            end
         end
         OP_CLOSE: begin
            if ((IDX >= pos) && ((IDX + XW'(1)) < count)) begin
               entry_in = right_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
   assign rd_tap      = (IDX == rd_idx)   ? entry_ff : '0;
   assign back_tap    = (IDX == back_idx) ? entry_ff : '0;

endmodule

>>> hw/rtl/indexed_insert_erase_list_unit.sv
// ----------------------------------------------------------------------------
// indexed_insert_erase_list_unit
// Ordered list of signed 32-bit words with fixed capacity, held in a row of
// cells that shift in parallel on insert and erase.
//
//   channel | dir | handshake           | beat
//   --------+-----+---------------------+----------------------------------
//   req     | in  | req_valid/req_ready | command, value, position
//   rsp     | out | rsp_valid/rsp_ready | read_value, status, count,
//           |     |                     | front_value, back_value
//
// Each command passes the idle state, where every cell shifts or loads at once,
// then the look-up state, where the selected read and back entries are picked
// off the row into the output register; no new command is taken meanwhile.
// Reset clears the count and the control state; cell contents stay as they
// are and are never read before being written.
// A stalled result holds in the output register; the next command is taken
// meanwhile and waits in its look-up state until the output frees.
// ----------------------------------------------------------------------------
module indexed_insert_erase_list_unit #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  iiel_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output iiel_pkg::rsp_type rsp_payload
);
   import iiel_pkg::*;

   // Count width and a compare width that covers both count and position
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > 7) ? CW : 7) + 1;

   typedef enum logic {
      S_IDLE,
      S_LOOK
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   status_type         status_ff;
   status_type         status_in;
   logic               rd_ok_ff;
   logic               rd_ok_in;
   logic [6:0]         pos_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               accept;
   logic [XW-1:0]      count_x;
   logic [XW-1:0]      pos_x;
   logic               full;
   logic               empty;
   shift_op_type       op;
   logic [XW-1:0]      op_pos;

   logic [XW-1:0]      rd_idx;
   logic [XW-1:0]      back_idx;
   logic signed [31:0] entry_value [CAPACITY];
   logic signed [31:0] left_value  [CAPACITY];
   logic signed [31:0] right_value [CAPACITY];
   logic signed [31:0] rd_tap      [CAPACITY];
   logic signed [31:0] back_tap    [CAPACITY];
   logic signed [31:0] rd_sel;
   logic signed [31:0] back_sel;

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign count_x = XW'(count_ff);
   assign pos_x   = XW'(req_payload.position);
   assign full    = (count_x == XW'(CAPACITY));
   assign empty   = (count_ff == '0);

   // Decode the command against the current count; broadcast a shift only
   // when the command succeeds and the beat is taken.
   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      rd_ok_in  = 1'b0;
      op        = OP_HOLD;
      op_pos    = pos_x;
      unique case (req_payload.command)
         CMD_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               op       = OP_OPEN;
               op_pos   = count_x;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_POP: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         CMD_INSERT: begin
            if (pos_x > count_x) begin
               status_in = ST_BADPOS;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               op       = OP_OPEN;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_ERASE: begin
            if (pos_x >= count_x) begin
               status_in = ST_BADPOS;
            end else begin
               op       = OP_CLOSE;
               count_in = count_ff - CW'(1);
            end
         end
         CMD_READ: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (pos_x >= count_x) begin
               status_in = ST_BADPOS;
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      if (!accept) begin
         op = OP_HOLD;
      end
   end

   // Look-up selects: count_ff already holds the post-command count here.
   // An empty list wraps back_idx to all ones, which matches no cell.
   assign rd_idx   = rd_ok_ff ? XW'(pos_ff) : '1;
   assign back_idx = count_x - XW'(1);

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign left_value[g] = '0;
      end else begin : g_mid_l
         assign left_value[g] = entry_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_value[g] = '0;
      end else begin : g_mid_r
         assign right_value[g] = entry_value[g+1];
      end

      iiel_cell #(
         .INDEX (g),
         .XW    (XW)
      ) u_cell (
         .clock       (clock),
         .op          (op),
         .pos         (op_pos),
         .count       (count_x),
         .value       (req_payload.value),
         .left_value  (left_value[g]),
         .right_value (right_value[g]),
         .rd_idx      (rd_idx),
         .back_idx    (back_idx),
         .entry_value (entry_value[g]),
         .rd_tap      (rd_tap[g]),
         .back_tap    (back_tap[g])
      );
   end

   // At most one cell drives each tap, so OR the taps together
   always_comb begin
      rd_sel   = '0;
      back_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_sel   = rd_sel | rd_tap[i];
         back_sel = back_sel | back_tap[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         status_ff    <= ST_OK;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               // Drop the pending result once taken
               if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  count_ff  <= count_in;
                  status_ff <= status_in;
                  rd_ok_ff  <= rd_ok_in;
                  pos_ff    <= req_payload.position;
                  state_ff  <= S_LOOK;
               end
            end
            S_LOOK: begin
               // Hold until the output register is free, then load it
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.read_value  <= rd_sel;
                  rsp_ff.status      <= status_ff;
                  rsp_ff.count       <= 7'(count_ff);
                  rsp_ff.front_value <= (count_ff != '0) ? entry_value[0] : '0;
                  rsp_ff.back_value  <= back_sel;
                  rsp_valid_ff       <= 1'b1;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      XW'(count_ff) <= XW'(CAPACITY))
      else $error("list count above capacity");

   a_count_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("list count moved without an accepted beat");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK) && (status_ff == ST_FULL) |-> (count_x == XW'(CAPACITY)))
      else $error("full status on a list that is not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK) && (status_ff == ST_EMPTY) |-> (count_ff == '0))
      else $error("empty status on a list that holds entries");
`endif

endmodule
